@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ sv/rgbhsv_pkg.sv @@
// ---------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants for the RGB to HSV pixel converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    // Field widths
    localparam int CHAN_W = 8;
    localparam int OUT_W  = 15;

    // Default hue resolution: 1/64 degree
    localparam int HUE_FRAC_DEFAULT = 6;

    // Percent scale in 1/256 units
    localparam int PCT_SCALE = 25600;

    // Value = 100*max + floor(100*max / 255); the division is a multiply
    // by ceil(2^23 / 255), exact for products below 2^15
    localparam int          VAL_MULT    = 100;
    localparam logic [15:0] VAL_RECIP   = 16'd32897;
    localparam int          VAL_SHIFT   = 23;

    // Quotient bits resolved per divider pipeline stage
    localparam int DIV_STEPS = 4;

    // Channel holding the maximum, which picks the hue sector
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

endpackage

`default_nettype wire

@@ sv/rgb_to_hsv_converter.sv @@
// ---------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined RGB to HSV conversion, one 8-bit pixel per clock while not stalled.
// ---------------------------------------------------------------------------
// Accepts one pixel per clock unless a stalled output has filled the pipeline,
// and returns hue (1/2^HUE_FRACTION_BITS degree), saturation and value (percent
// in 1/256 units) in the same order. The pipeline has one stage for max/min and
// sector selection, DIV_STAGES stages of two restoring dividers that resolve
// four quotient bits each (hue and saturation quotients, 23 dividend bits),
// and one output stage that places the hue in its sector and finishes the
// value scaling. Every stage carries a valid bit and loads whenever it is
// empty or its successor moves, so bubbles are squeezed out and a stalled
// output only blocks the input once the whole pipeline is full.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsv_converter #(
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::HUE_FRAC_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] s_red,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] s_green,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] s_blue,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rgbhsv_pkg::OUT_W-1:0]  m_hue,
    output logic [rgbhsv_pkg::OUT_W-1:0]  m_saturation,
    output logic [rgbhsv_pkg::OUT_W-1:0]  m_brightness
);
    import rgbhsv_pkg::*;

    // Hue scaling
    localparam int DEG      = 1 << HUE_FRACTION_BITS;
    localparam int SECTOR   = 60 * DEG;
    localparam int HUE_FULL = 360 * DEG;
    localparam int HUE_W    = $clog2(HUE_FULL);
    localparam int HQ_W     = $clog2(SECTOR + 1);

    // Divider sizing
    localparam int CHAN_MAX   = (1 << CHAN_W) - 1;
    localparam int HNUM_W     = $clog2(CHAN_MAX * SECTOR + 1);
    localparam int SNUM_W     = $clog2(CHAN_MAX * PCT_SCALE + 1);
    localparam int DIV_W      = (HNUM_W > SNUM_W) ? HNUM_W : SNUM_W;
    localparam int DIV_STAGES = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_PAD    = DIV_STAGES * DIV_STEPS;
    localparam int NS         = DIV_STAGES + 2;

    // Per-pixel pipeline word; num fields end up holding the quotients
    typedef struct packed {
        logic [DIV_PAD-1:0] hnum;
        logic [CHAN_W-1:0]  hrem;
        logic [CHAN_W-1:0]  hden;
        logic [DIV_PAD-1:0] snum;
        logic [CHAN_W-1:0]  srem;
        logic [CHAN_W-1:0]  sden;
        sector_t            sect;
        logic               neg;
        logic [OUT_W-1:0]   vscaled;
    } pix_t;

    pix_t             pipe_reg [DIV_STAGES+1];
    pix_t             s0_next;
    logic [NS-1:0]    valid_reg;
    logic [NS:0]      adv;

    logic [OUT_W-1:0] hue_reg, sat_reg, val_reg;
    logic [OUT_W-1:0] hue_next, sat_next, val_next;

    // Stage enables: a stage loads when empty or when its successor moves
    assign adv[NS] = m_ready;
    for (genvar i = 0; i < NS; i++) begin : g_adv
        assign adv[i] = ~valid_reg[i] | adv[i+1];
    end
    assign s_ready = adv[0];

    // Stage 0: max, min, spread, sector and signed channel difference
    always_comb begin
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] mn;
        logic [CHAN_W-1:0] spread;
        logic [CHAN_W-1:0] adiff;

        mx = s_red;
        if (s_green > mx) mx = s_green;
        if (s_blue > mx)  mx = s_blue;
        mn = s_red;
        if (s_green < mn) mn = s_green;
        if (s_blue < mn)  mn = s_blue;
        spread = mx - mn;

        s0_next = '0;
        if (mx == s_red) begin
            s0_next.sect = SECT_RED;
            s0_next.neg  = (s_green < s_blue);
            adiff        = s0_next.neg ? (s_blue - s_green) : (s_green - s_blue);
        end else if (mx == s_green) begin
            s0_next.sect = SECT_GREEN;
            s0_next.neg  = (s_blue < s_red);
            adiff        = s0_next.neg ? (s_red - s_blue) : (s_blue - s_red);
        end else begin
            s0_next.sect = SECT_BLUE;
            s0_next.neg  = (s_red < s_green);
            adiff        = s0_next.neg ? (s_green - s_red) : (s_red - s_green);
        end

        s0_next.hnum    = DIV_PAD'(32'(adiff) * SECTOR);
        s0_next.hden    = spread;
        s0_next.snum    = DIV_PAD'(32'(spread) * PCT_SCALE);
        s0_next.sden    = mx;
        s0_next.vscaled = OUT_W'(32'(mx) * VAL_MULT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv[0]) begin
            valid_reg[0] <= s_valid;
        end
        if (adv[0]) begin
            pipe_reg[0] <= s0_next;
        end
    end

    // Divider stages: restoring division, DIV_STEPS quotient bits per stage
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        pix_t stage_next;

        always_comb begin
            logic [CHAN_W:0]    hr;
            logic [CHAN_W:0]    sr;
            logic [DIV_PAD-1:0] hn;
            logic [DIV_PAD-1:0] sn;

            stage_next = pipe_reg[k-1];
            hr = {1'b0, pipe_reg[k-1].hrem};
            sr = {1'b0, pipe_reg[k-1].srem};
            hn = pipe_reg[k-1].hnum;
            sn = pipe_reg[k-1].snum;
            for (int j = 0; j < DIV_STEPS; j++) begin
                // shift the next dividend bit into the partial remainder
                hr = {hr[CHAN_W-1:0], hn[DIV_PAD-1]};
                hn = {hn[DIV_PAD-2:0], 1'b0};
                if (hr >= {1'b0, pipe_reg[k-1].hden}) begin
                    hr    = hr - {1'b0, pipe_reg[k-1].hden};
                    hn[0] = 1'b1;
                end
                sr = {sr[CHAN_W-1:0], sn[DIV_PAD-1]};
                sn = {sn[DIV_PAD-2:0], 1'b0};
                if (sr >= {1'b0, pipe_reg[k-1].sden}) begin
                    sr    = sr - {1'b0, pipe_reg[k-1].sden};
                    sn[0] = 1'b1;
                end
            end
            stage_next.hrem = hr[CHAN_W-1:0];
            stage_next.srem = sr[CHAN_W-1:0];
            stage_next.hnum = hn;
            stage_next.snum = sn;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv[k]) begin
                valid_reg[k] <= valid_reg[k-1];
            end
            if (adv[k]) begin
                pipe_reg[k] <= stage_next;
            end
        end
    end

    // Output stage: sector offset, red wrap, grey and black overrides, value
    always_comb begin
        pix_t                      fin;
        logic [HQ_W-1:0]           hq;
        logic [HUE_W-1:0]          hue;
        logic [OUT_W+15:0]         vprod;

        fin = pipe_reg[DIV_STAGES];
        hq  = fin.hnum[HQ_W-1:0];

        case (fin.sect)
            SECT_RED: begin
                if (fin.neg && (hq != '0)) begin
                    hue = HUE_W'(HUE_FULL) - HUE_W'(hq);
                end else begin
                    hue = HUE_W'(hq);
                end
            end
            SECT_GREEN: begin
                hue = fin.neg ? (HUE_W'(2 * SECTOR) - HUE_W'(hq))
                              : (HUE_W'(2 * SECTOR) + HUE_W'(hq));
            end
            SECT_BLUE: begin
                hue = fin.neg ? (HUE_W'(4 * SECTOR) - HUE_W'(hq))
                              : (HUE_W'(4 * SECTOR) + HUE_W'(hq));
            end
            default: begin
                hue = '0;
            end
        endcase

        // grey pixel: no spread, no hue
        if (fin.hden == '0) hue = '0;
        hue_next = OUT_W'(hue);

        // black pixel: no saturation
        sat_next = (fin.sden == '0) ? '0 : fin.snum[OUT_W-1:0];

        vprod    = fin.vscaled * VAL_RECIP;
        val_next = fin.vscaled + OUT_W'(vprod >> VAL_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[NS-1] <= 1'b0;
        end else if (adv[NS-1]) begin
            valid_reg[NS-1] <= valid_reg[NS-2];
        end
        if (adv[NS-1]) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign m_valid      = valid_reg[NS-1];
    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = val_reg;

    // Checks
    `ASSERT_IMPLY(a_blocked_only_when_full, aclk, aresetn, !s_ready, &valid_reg)
    `ASSERT_NEXT(a_head_stage_holds, aclk, aresetn, valid_reg[0] && !adv[1], valid_reg[0])
    `ASSERT_IMPLY(a_grey_has_zero_hue, aclk, aresetn, m_valid && (m_saturation == '0), m_hue == '0)
    `ASSERT_IMPLY(a_pct_in_range, aclk, aresetn, m_valid, (m_saturation <= OUT_W'(PCT_SCALE)) && (m_brightness <= OUT_W'(PCT_SCALE)))

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_hsv_converter: a directed table of corner
// pixels, then random pixel streams with gaps and stalls on both sides, each
// result checked field by field against table rows or an in-bench HSV model.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    import rgbhsv_pkg::*;

    localparam int HUE_FRAC     = HUE_FRAC_DEFAULT;
    localparam int CHAN_MAX     = 255;
    localparam int SEG_ITEMS    = 50;
    localparam int SEG_COUNT    = 39;
    localparam int HOLD_SEG     = 5;
    localparam int DRAIN_SEG    = 20;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int ROWS         = 22;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [OUT_W-1:0] hue;
        logic [OUT_W-1:0] sat;
        logic [OUT_W-1:0] val;
    } hsv_t;

    // One directed row; hue/sat/val only used when 'typed' is set
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        bit                typed;
        logic [OUT_W-1:0]  hue;
        logic [OUT_W-1:0]  sat;
        logic [OUT_W-1:0]  val;
    } pixel_row_t;

    localparam pixel_row_t CORNER_PIXELS [ROWS] = '{
        '{  0,   0,   0, 1,     0,     0,     0},  // black
        '{255, 255, 255, 1,     0,     0, 25600},  // white
        '{255,   0,   0, 1,     0, 25600, 25600},  // pure red
        '{  0, 255,   0, 1,  7680, 25600, 25600},  // pure green
        '{  0,   0, 255, 1, 15360, 25600, 25600},  // pure blue
        '{255, 255,   0, 1,  3840, 25600, 25600},  // yellow, red wins tie
        '{  0, 255, 255, 1, 11520, 25600, 25600},  // cyan, green wins tie
        '{255,   0, 255, 1, 19200, 25600, 25600},  // magenta, negative wrap
        '{128, 128, 128, 0,     0,     0,     0},  // mid grey
        '{  1,   1,   1, 0,     0,     0,     0},  // darkest grey
        '{255,   0,   1, 0,     0,     0,     0},  // small negative red hue
        '{200,  10,  11, 0,     0,     0,     0},
        '{  1,   0,   0, 0,     0,     0,     0},
        '{  0,   1,   0, 0,     0,     0,     0},
        '{  0,   0,   1, 0,     0,     0,     0},
        '{170,  85, 255, 0,     0,     0,     0},
        '{100, 200, 200, 0,     0,     0,     0},  // green/blue tie
        '{200, 100, 200, 0,     0,     0,     0},  // red/blue tie
        '{200, 200, 100, 0,     0,     0,     0},  // red/green tie
        '{254, 255, 255, 0,     0,     0,     0},
        '{  0, 128, 255, 0,     0,     0,     0},
        '{ 85, 170,  85, 0,     0,     0,     0}
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CHAN_W-1:0] s_red = '0;
    logic [CHAN_W-1:0] s_green = '0;
    logic [CHAN_W-1:0] s_blue = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [OUT_W-1:0]  m_hue;
    logic [OUT_W-1:0]  m_saturation;
    logic [OUT_W-1:0]  m_brightness;

    hsv_t hsv_expected[$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   steady_flow = 1'b0;
    bit   hold_request = 1'b0;

    rgb_to_hsv_converter #(
        .HUE_FRACTION_BITS(HUE_FRAC)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    // HSV of one pixel: integer math, quotients truncated toward zero
    function automatic hsv_t hsv_predict(input pixel_t px);
        int      r;
        int      g;
        int      b;
        int      deg;
        int      sixty;
        int      hi;
        int      lo;
        int      spread;
        int      hue;
        int      sat;
        sector_t sect;
        hsv_t    res;
        r     = int'(px.red);
        g     = int'(px.green);
        b     = int'(px.blue);
        deg   = 1 << HUE_FRAC;
        sixty = 60 * deg;
        hi    = r;
        lo    = r;
        sect  = SECT_RED;
        if (g > hi) begin
            hi   = g;
            sect = SECT_GREEN;
        end
        if (b > hi) begin
            hi   = b;
            sect = SECT_BLUE;
        end
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        spread = hi - lo;
        hue    = 0;
        sat    = 0;
        if (spread != 0) begin
            case (sect)
                SECT_RED: begin
                    hue = (sixty * (g - b)) / spread;
                    if (hue < 0) hue += 360 * deg;
                end
                SECT_GREEN: hue = 2 * sixty + (sixty * (b - r)) / spread;
                default:    hue = 4 * sixty + (sixty * (r - g)) / spread;
            endcase
        end
        if (hi != 0) sat = (spread * PCT_SCALE) / hi;
        res.hue = hue[OUT_W-1:0];
        res.sat = sat[OUT_W-1:0];
        res.val = 15'((hi * PCT_SCALE) / CHAN_MAX);
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] edge_or_any();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return CHAN_W'(CHAN_MAX);
            default: return CHAN_W'($urandom_range(0, CHAN_MAX));
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] nudge(input int base);
        int v;
        v = base + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > CHAN_MAX) v = CHAN_MAX;
        return CHAN_W'(v);
    endfunction

    // Random pixel, weighted toward grey, ties, extremes and near-grey
    function automatic pixel_t random_pixel();
        pixel_t px;
        int     base;
        base     = $urandom_range(0, CHAN_MAX);
        px.red   = CHAN_W'($urandom_range(0, CHAN_MAX));
        px.green = CHAN_W'($urandom_range(0, CHAN_MAX));
        px.blue  = CHAN_W'($urandom_range(0, CHAN_MAX));
        case ($urandom_range(0, 9))
            6: px = '{CHAN_W'(base), CHAN_W'(base), CHAN_W'(base)};
            7: px = '{edge_or_any(), edge_or_any(), edge_or_any()};
            8: begin
                case ($urandom_range(0, 2))
                    0:       px.green = px.red;
                    1:       px.blue = px.red;
                    default: px.blue = px.green;
                endcase
            end
            9: px = '{nudge(base), nudge(base), nudge(base)};
            default: ;
        endcase
        return px;
    endfunction

    // Offer one pixel transaction and record what should come back
    task automatic send_pixel(input pixel_t px, input bit typed, input hsv_t want);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= px.red;
        s_green <= px.green;
        s_blue  <= px.blue;
        do @(posedge aclk); while (!s_ready);
        hsv_expected.push_back(typed ? want : hsv_predict(px));
    endtask

    // Stop offering until every outstanding result has come back
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (hsv_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic compare_pixel_result();
        hsv_t want;
        if (hsv_expected.size() == 0) begin
            $error("unexpected result: hue %0d sat %0d val %0d",
                   m_hue, m_saturation, m_brightness);
            error_count++;
        end else begin
            want = hsv_expected.pop_front();
            if (m_hue !== want.hue) begin
                $error("hue: expected %0d, actual %0d", want.hue, m_hue);
                error_count++;
            end
            if (m_saturation !== want.sat) begin
                $error("saturation: expected %0d, actual %0d", want.sat, m_saturation);
                error_count++;
            end
            if (m_brightness !== want.val) begin
                $error("brightness: expected %0d, actual %0d", want.val, m_brightness);
                error_count++;
            end
        end
    endtask

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Cycle counter and timeout
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: errors");
        $finish;
    end

    // Result side: check accepted transactions, randomize back-pressure
    initial begin
        int   stall_left;
        int   gap;
        logic next_ready;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) compare_pixel_result();
            if (hold_request) begin
                stall_left   = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall_left > 0) begin
                next_ready = 1'b0;
                stall_left--;
            end else if (steady_flow || !aresetn) begin
                next_ready = aresetn;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    stall_left = gap - 1;
                    next_ready = 1'b0;
                end else begin
                    next_ready = 1'b1;
                end
            end
            m_ready <= next_ready;
        end
    end

    // Pixel side: reset, directed corners, random segments, drain, verdict
    initial begin
        pixel_row_t row;
        hsv_t       want;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corner pixels
        for (int i = 0; i < ROWS; i++) begin
            row  = CORNER_PIXELS[i];
            want = '{row.hue, row.sat, row.val};
            send_pixel('{row.red, row.green, row.blue}, row.typed, want);
        end
        drain_pipeline();

        // Random segments; one long receiver hold, one full drain
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            if (seg == HOLD_SEG) begin
                steady_flow  = 1'b0;
                hold_request = 1'b1;
            end
            if (seg == DRAIN_SEG) drain_pipeline();
            for (int n = 0; n < SEG_ITEMS; n++) begin
                if (seg == HOLD_SEG) steady_flow = 1'b1;
                send_pixel(random_pixel(), 1'b0, '0);
            end
        end
        steady_flow = 1'b0;
        s_valid <= 1'b0;

        while (hsv_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
